>>> design/mlpf_pkg.sv
// shared types and constants of the modulated low-pass filter
`timescale 1ns / 1ps

package mlpf_pkg;

	localparam int DIV_W    = 37;
	localparam int DIV_LO_W = 32;
	localparam int ITER_W   = 6;

	localparam logic [ITER_W-1:0] W_ITERS = 6'd27;
	localparam logic [ITER_W-1:0] Q_ITERS = 6'd32;

	localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
	localparam logic [21:0] RECIP20    = 22'd3355444;
	localparam logic [17:0] FS_MIN     = 18'd8000;
	localparam logic [17:0] FS_MAX     = 18'd192000;
	localparam logic [17:0] FS_RESET   = 18'd48000;
	localparam logic signed [37:0] FOUR_Q24 = 38'sd67108864;

	localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    rem_init;
		logic [DIV_LO_W-1:0] num_lo;
		logic [DIV_W-1:0]    divisor;
		logic [ITER_W-1:0]   iters;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [DIV_LO_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic signed [31:0] ym2;
		logic signed [31:0] ym1;
		logic signed [31:0] yn;
		logic signed [23:0] xm2;
		logic signed [23:0] xm1;
		logic signed [23:0] xn;
	} hist_t;

endpackage

>>> design/mlpf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mlpf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mlpf_pkg::div_req_t req,
	output mlpf_pkg::div_rsp_t rsp
);
	import mlpf_pkg::*;

	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    div_q;
	logic [DIV_LO_W-1:0] lo_q;
	logic [DIV_LO_W-1:0] quot_q;
	logic [ITER_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DIV_W:0]      trial;
	logic [DIV_W:0]      diff;
	logic                ge;

	assign trial = {rem_q, lo_q[DIV_LO_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			div_q  <= req.divisor;
			lo_q   <= req.num_lo;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			lo_q   <= {lo_q[DIV_LO_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_LO_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> design/modulated_lowpass_filter.sv
// top level: per-channel modulated low-pass filter with history memory
//
//  channel   role    fields (lowest bit up)
//  apb       config  sample_rate_hz at address 0
//  s_axis    input   tdata: sample_in, cutoff_hz, q_raw; tuser: channel
//  m_axis    output  tdata: sample_out; tuser: channel_out
//
//  one sample at a time: the next input transfer is taken only after the result
//  has been loaded into the output register
//  the pace is set by two serial divisions (27 and 32 steps) on one divider
//  and eight passes through the shared 38x32 multiplier
//  the next sample is taken while the previous result waits in the output register
//  reset clears the history valid bits at once, no clearing pass
`timescale 1ns / 1ps

module modulated_lowpass_filter #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // sample_in, cutoff_hz, q_raw, zero fill
	input  logic [2:0]  s_tuser,  // channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // sample_out
	output logic [2:0]  m_tuser   // channel_out
);
	import mlpf_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FMAX, ST_FCLAMP, ST_WMUL, ST_WDIV, ST_WWAIT,
		ST_AMUL, ST_TMUL, ST_COEF, ST_K, ST_M0, ST_M1, ST_M2, ST_M3,
		ST_ACC, ST_DSTART, ST_DWAIT, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [17:0] sample_rate_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SAMPLE_RATE);
	assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? {14'b0, sample_rate_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= FS_RESET;
		end else if (cfg_we) begin
			sample_rate_q <= pwdata[17:0];
		end
	end

	// input decode
	logic                s_xfer;
	logic [IDX_W+2:0]    in_ch_ext;
	logic                in_ok;
	logic [IDX_W-1:0]    in_idx;
	logic [17:0]         fs_clamp;
	logic [15:0]         q_abs;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign in_ch_ext = {{IDX_W{1'b0}}, s_tuser};
	assign in_ok     = in_ch_ext < (IDX_W+3)'(CHANNELS);
	assign in_idx    = in_ok ? in_ch_ext[IDX_W-1:0] : '0;
	assign q_abs     = s_tdata[56] ? (~s_tdata[56:41] + 16'd1) : s_tdata[56:41];

	always_comb begin
		if (sample_rate_q < FS_MIN) begin
			fs_clamp = FS_MIN;
		end else if (sample_rate_q > FS_MAX) begin
			fs_clamp = FS_MAX;
		end else begin
			fs_clamp = sample_rate_q;
		end
	end

	// item registers
	logic [IDX_W-1:0]    idx_q;
	logic [2:0]          ch_q;
	logic                bad_q;
	logic signed [23:0]  x_q;
	logic [16:0]         f_q;
	logic [15:0]         qa_q;
	logic [17:0]         fsc_q;
	logic [20:0]         fs9_q;
	hist_t               hist_q;
	logic signed [26:0]  xs_q;
	logic [26:0]         w_q;
	logic [27:0]         a_q;
	logic [36:0]         t_q;
	logic [36:0]         d_q;
	logic signed [37:0]  k0_q;
	logic signed [37:0]  k1_q;
	logic signed [37:0]  k2_q;
	logic signed [69:0]  prod_q;
	logic signed [71:0]  acc_q;
	logic                neg_q;
	logic                ovf_q;
	logic signed [31:0]  y_q;

	// history memory with valid bits
	hist_t               mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	hist_t               rd_q;
	logic                rd_vld_q;
	logic                mem_we;
	hist_t               wr_data;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			rd_q <= mem[in_idx];
		end
		if (mem_we) begin
			mem[idx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				rd_vld_q <= vld_q[in_idx];
			end
			if (mem_we) begin
				vld_q[idx_q] <= 1'b1;
			end
		end
	end

	// shared multiplier
	logic signed [37:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [69:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_FMAX: begin
				mul_a = {16'b0, RECIP20};
				mul_b = {11'b0, fs9_q};
			end
			ST_WMUL: begin
				mul_a = {3'b0, TWO_PI_Q32};
				mul_b = {15'b0, f_q};
			end
			ST_AMUL: begin
				mul_a = {11'b0, w_q};
				mul_b = {5'b0, w_q};
			end
			ST_TMUL: begin
				mul_a = {11'b0, w_q};
				mul_b = {16'b0, qa_q};
			end
			ST_M0: begin
				mul_a = {10'b0, a_q};
				mul_b = {{5{xs_q[26]}}, xs_q};
			end
			ST_M1: begin
				mul_a = k0_q;
				mul_b = hist_q.yn;
			end
			ST_M2: begin
				mul_a = k1_q;
				mul_b = hist_q.ym1;
			end
			ST_M3: begin
				mul_a = k2_q;
				mul_b = hist_q.ym2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// datapath helpers
	logic [16:0]        fmax;
	logic [16:0]        f_clamped;
	logic signed [26:0] e0, e1, e2, ein;
	logic [51:0]        wnum;
	logic [52:0]        a_sum;
	logic [42:0]        t_sum;
	logic signed [37:0] as_s, ts_s, a3_s;
	logic [71:0]        mag;
	logic               ovf;
	logic signed [71:0] prod_ext;
	logic [31:0]        qd;
	logic signed [31:0] y32;
	logic [23:0]        y24;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign fmax = prod_q[42:26];
	always_comb begin
		if (f_q == 17'd0) begin
			f_clamped = 17'd1;
		end else if (f_q > fmax) begin
			f_clamped = fmax;
		end else begin
			f_clamped = f_q;
		end
	end

	assign e0  = {{3{hist_q.xn[23]}}, hist_q.xn};
	assign e1  = {{3{hist_q.xm1[23]}}, hist_q.xm1};
	assign e2  = {{3{hist_q.xm2[23]}}, hist_q.xm2};
	assign ein = {{3{x_q[23]}}, x_q};

	assign wnum  = prod_q[51:0] + {27'b0, fsc_q, 7'b0};
	assign a_sum = prod_q[52:0] + 53'd8388608;
	assign t_sum = prod_q[42:0] + 43'd16;
	assign as_s  = {10'b0, a_q};
	assign ts_s  = {1'b0, t_q};
	assign a3_s  = as_s + (as_s <<< 1);

	assign mag      = acc_q[71] ? ~acc_q : acc_q;
	assign ovf      = mag[71:32] >= {3'b0, d_q};
	assign prod_ext = {{2{prod_q[69]}}, prod_q};

	assign qd = div_rsp.quot;
	always_comb begin
		if (ovf_q || qd[31]) begin
			y32 = neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			y32 = neg_q ? ~qd : qd;
		end
	end

	always_comb begin
		if (!y_q[31] && (y_q[30:23] != 8'h00)) begin
			y24 = 24'h7FFFFF;
		end else if (y_q[31] && (y_q[30:23] != 8'hFF)) begin
			y24 = 24'h800000;
		end else begin
			y24 = y_q[23:0];
		end
	end

	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_WDIV: begin
				div_req.start    = 1'b1;
				div_req.rem_init = {12'b0, wnum[51:27]};
				div_req.num_lo   = {wnum[26:0], 5'b0};
				div_req.divisor  = {11'b0, fsc_q, 8'b0};
				div_req.iters    = W_ITERS;
			end
			ST_DSTART: begin
				div_req.start    = 1'b1;
				div_req.rem_init = mag[68:32];
				div_req.num_lo   = mag[31:0];
				div_req.divisor  = d_q;
				div_req.iters    = Q_ITERS;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	mlpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				idx_q <= in_idx;
				ch_q  <= s_tuser;
				bad_q <= !in_ok;
				x_q   <= s_tdata[23:0];
				f_q   <= s_tdata[40:24];
				qa_q  <= q_abs;
				fsc_q <= fs_clamp;
				fs9_q <= {fs_clamp, 3'b0} + {3'b0, fs_clamp};
			end
			ST_FMAX: begin
				hist_q <= rd_vld_q ? rd_q : '0;
			end
			ST_FCLAMP: begin
				f_q  <= f_clamped;
				xs_q <= e2 + e1 + (e1 <<< 1) + e0 + (e0 <<< 1) + ein;
			end
			ST_WWAIT: begin
				if (div_rsp.done) begin
					w_q <= div_rsp.quot[26:0];
				end
			end
			ST_TMUL: begin
				a_q <= a_sum[51:24];
			end
			ST_COEF: begin
				t_q <= t_sum[41:5];
			end
			ST_K: begin
				k0_q <= ts_s - FOUR_Q24 + a3_s;
				k1_q <= a3_s - ts_s - FOUR_Q24;
				k2_q <= as_s - ts_s + FOUR_Q24;
				d_q  <= {9'b0, a_q} + t_q + 37'd67108864;
			end
			ST_M1: begin
				acc_q <= prod_ext + {36'b0, d_q[36:1]};
			end
			ST_M2, ST_M3, ST_ACC: begin
				acc_q <= acc_q - prod_ext;
			end
			ST_DSTART: begin
				neg_q <= acc_q[71];
				ovf_q <= ovf;
			end
			ST_DWAIT: begin
				if (div_rsp.done) begin
					y_q <= y32;
				end
			end
			default: begin
			end
		endcase
	end

	logic can_load;

	assign can_load = !m_tvalid || m_tready;
	assign mem_we   = (state_q == ST_OUT) && can_load && !bad_q;

	assign wr_data.ym2 = hist_q.ym1;
	assign wr_data.ym1 = hist_q.yn;
	assign wr_data.yn  = y_q;
	assign wr_data.xm2 = hist_q.xm1;
	assign wr_data.xm1 = hist_q.xn;
	assign wr_data.xn  = x_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else begin
			if ((state_q == ST_OUT) && can_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (s_xfer) state_q <= ST_FMAX;
				ST_FMAX:   state_q <= ST_FCLAMP;
				ST_FCLAMP: state_q <= ST_WMUL;
				ST_WMUL:   state_q <= ST_WDIV;
				ST_WDIV:   state_q <= ST_WWAIT;
				ST_WWAIT:  if (div_rsp.done) state_q <= ST_AMUL;
				ST_AMUL:   state_q <= ST_TMUL;
				ST_TMUL:   state_q <= ST_COEF;
				ST_COEF:   state_q <= ST_K;
				ST_K:      state_q <= ST_M0;
				ST_M0:     state_q <= ST_M1;
				ST_M1:     state_q <= ST_M2;
				ST_M2:     state_q <= ST_M3;
				ST_M3:     state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT:  if (div_rsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (can_load) begin
						m_tdata  <= bad_q ? 24'h000000 : y24;
						m_tuser  <= ch_q;
						state_q  <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_rsp.busy)
		else $error("divider busy while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> ((state_q == ST_WWAIT) || (state_q == ST_DWAIT)))
		else $error("division finished outside a wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !bad_q && (state_q == ST_OUT))
		else $error("history written for a bad channel");
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && can_load) |=> m_tvalid && (state_q == ST_IDLE))
		else $error("result not presented");
`endif

endmodule

>>> test/modulated_lowpass_filter_tb.sv
// testbench of the modulated low-pass filter: random and directed samples against a predictor
`timescale 1ns / 1ps

class lowpass_scoreboard;
	logic [17:0]        rate_hz;
	longint             x_hist[8][3];
	longint             y_hist[8][3];
	logic [23:0]        want_sample[$];
	logic [2:0]         want_chan[$];
	int                 mismatches;

	function new();
		rate_hz = mlpf_pkg::FS_RESET;
		mismatches = 0;
		for (int c = 0; c < 8; c++)
			for (int i = 0; i < 3; i++) begin
				x_hist[c][i] = 0;
				y_hist[c][i] = 0;
			end
	endfunction

	static function longint div_floor(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function void note_sample(logic [2:0] chan, logic signed [23:0] smp,
			logic [16:0] cut, logic signed [15:0] qr);
		longint fs, fmax, f, qa, w, a, t, b, cc, d, xs, hi, lo, q1, r1, q2, y, yl, yh;
		longint k[3];
		longint unsigned den, num;
		fs = rate_hz;
		if (fs < 8000) fs = 8000;
		if (fs > 192000) fs = 192000;
		fmax = (fs * 9) / 20;
		f = cut;
		if (f < 1) f = 1;
		if (f > fmax) f = fmax;
		qa = qr;
		if (qa < 0) qa = -qa;
		den = fs * 256;
		num = 64'd26986075409 * f + den / 2;
		w = num / den;
		a = (w * w + 8388608) / 16777216;
		t = (w * qa + 16) / 32;
		b = t + 67108864;
		cc = t - 67108864;
		d = a + b;
		k[0] = cc + 3 * a;
		k[1] = 3 * a - b;
		k[2] = a - cc;
		xs = x_hist[chan][2] + 3 * x_hist[chan][1] + 3 * x_hist[chan][0] + longint'(smp);
		hi = 0;
		lo = a * xs + d / 2;
		for (int i = 0; i < 3; i++) begin
			yl = y_hist[chan][i] & 64'hFFFF;
			yh = (y_hist[chan][i] - yl) / 65536;
			hi -= k[i] * yh;
			lo -= k[i] * yl;
		end
		q1 = div_floor(hi, d);
		r1 = hi - q1 * d;
		q2 = div_floor(r1 * 65536 + lo, d);
		y = q1 * 65536 + q2;
		if (y > 64'sd2147483647) y = 64'sd2147483647;
		if (y < -64'sd2147483648) y = -64'sd2147483648;
		x_hist[chan][2] = x_hist[chan][1];
		x_hist[chan][1] = x_hist[chan][0];
		x_hist[chan][0] = longint'(smp);
		y_hist[chan][2] = y_hist[chan][1];
		y_hist[chan][1] = y_hist[chan][0];
		y_hist[chan][0] = y;
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		want_sample.push_back(y[23:0]);
		want_chan.push_back(chan);
	endfunction

	function void check_result(logic [23:0] smp, logic [2:0] chan);
		logic [23:0] es;
		logic [2:0] ec;
		if (want_sample.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result sample=%h chan=%0d", smp, chan);
			return;
		end
		es = want_sample.pop_front();
		ec = want_chan.pop_front();
		if (es !== smp || ec !== chan) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected sample=%h chan=%0d, got sample=%h chan=%0d",
					es, ec, smp, chan);
		end
	endfunction
endclass

module modulated_lowpass_filter_tb;
	import mlpf_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = 0;  // sample_in, cutoff_hz, q_raw, zero fill
	logic [2:0]  s_tuser = 0;  // channel
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;      // sample_out
	logic [2:0]  m_tuser;      // channel_out

	lowpass_scoreboard filt = new();
	int hold_starts = 0;
	int hold_seen = 0;
	int hold_cycles = 0;
	int sink_wait = 0;

	always #2 clk = ~clk;

	modulated_lowpass_filter dut (.*);

	task automatic write_rate(logic [17:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {REG_SAMPLE_RATE, 2'b00}; pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		filt.rate_hz = val;
	endtask

	task automatic send_sample(logic [2:0] chan, logic [23:0] smp, logic [16:0] cut,
			logic [15:0] qr, bit gap);
		int g;
		g = gap ? $urandom_range(0, 18) : 0;
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= chan;
		s_tdata <= {7'd0, qr, cut, smp};
		do @(posedge clk); while (!s_tready);
		filt.note_sample(chan, smp, cut, qr);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (filt.want_sample.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic random_sample(bit gap);
		logic [16:0] cut;
		logic [23:0] smp;
		case ($urandom_range(0, 3))
			0: cut = 17'($urandom_range(0, 131071));
			1: cut = 17'($urandom_range(0, 2000));
			default: cut = 17'($urandom_range(0, 96000));
		endcase
		smp = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000)
			: 24'($urandom);
		send_sample(3'($urandom_range(0, 7)), smp, cut, 16'($urandom), gap);
	endtask

	// sink side with a random wait per result and an optional long hold
	always @(negedge clk) begin
		if (hold_seen != hold_starts) begin
			m_tready <= 0;
			hold_cycles <= 600;
			hold_seen <= hold_starts;
		end else if (hold_cycles > 0) begin
			m_tready <= 0;
			hold_cycles <= hold_cycles - 1;
		end else if (sink_wait > 0) begin
			m_tready <= 0;
			sink_wait <= sink_wait - 1;
		end else
			m_tready <= 1;
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) begin
			filt.check_result(m_tdata, m_tuser);
			sink_wait <= $urandom_range(0, 18);
		end

	initial begin
		logic [17:0] rates[6];
		rates = '{18'd8000, 18'd192000, 18'd44100, 18'd1000, 18'd262143, 18'd96000};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (3) @(negedge clk);
		// directed extremes at reset rate
		send_sample(3'd0, 24'h7FFFFF, 17'd0, 16'h0000, 1'b0);
		send_sample(3'd0, 24'h800000, 17'd1, 16'h7FFF, 1'b0);
		send_sample(3'd1, 24'h7FFFFF, 17'd96000, 16'h8000, 1'b0);
		send_sample(3'd7, 24'h800000, 17'h1FFFF, 16'hFFFF, 1'b0);
		send_sample(3'd2, 24'h000001, 17'd21600, 16'd128, 1'b0);
		for (int i = 0; i < 6; i++)
			send_sample(3'd3, i[0] ? 24'h7FFFFF : 24'h800000, 17'd21000, 16'h7FFF, 1'b0);
		drain();
		write_rate(18'd8000);
		send_sample(3'd4, 24'h7FFFFF, 17'd3600, 16'd181, 1'b0);
		send_sample(3'd4, 24'h800000, 17'd5000, 16'h8000, 1'b0);
		drain();
		// long sink hold while the source keeps offering
		hold_starts++;
		for (int i = 0; i < 8; i++) random_sample(1'b0);
		drain();
		for (int r = 0; r < 6; r++) begin
			write_rate(rates[r]);
			for (int i = 0; i < 180; i++) random_sample(1'b1);
			drain();
		end
		write_rate(18'($urandom));
		for (int i = 0; i < 20; i++) random_sample(1'b1);
		drain();
		if (filt.mismatches == 0 && filt.want_sample.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
